@@ sv/rsa_public_key_encoding_check_core_macros.svh @@
// Assertion macros shared by the key encoding check RTL.
// Each macro is empty when SYNTHESIS is defined.
`ifndef RSA_PUBLIC_KEY_ENCODING_CHECK_CORE_MACROS_SVH
`define RSA_PUBLIC_KEY_ENCODING_CHECK_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define RPKC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rpkc: assertion failed");

`define RPKC_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("rpkc: forbidden condition seen");

`else

`define RPKC_ASSERT(lbl, clk, rst, prop)

`define RPKC_NEVER(lbl, clk, rst, cond)

`endif

`endif

@@ sv/rpkc_pkg.sv @@
package rpkc_pkg;

   localparam int MAX_MODULUS_BYTES_DEF = 1024;

   localparam int BYTE_W        = 8;
   localparam int KEY_BITS_W    = 14;
   localparam int ENC_BYTES_W   = 12;
   localparam int DECL_W        = 32;
   localparam int WIDTH_W       = 12;
   localparam int TOP_BITS_W    = 4;
   localparam int HEADER_BYTES  = 4;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [ENC_BYTES_W-1:0] POSITION_MAX = {ENC_BYTES_W{1'b1}};

   localparam logic [KEY_BITS_W-1:0]  MIN_KEY_BITS_RST = 14'd1024;
   localparam logic [KEY_BITS_W-1:0]  MAX_KEY_BITS_RST = 14'd8192;
   localparam logic [ENC_BYTES_W-1:0] MAX_ENC_BYTES_RST = 12'd2052;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_KEY_BITS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_KEY_BITS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ENC_BYTES = 2'd2;

   typedef enum logic [1:0] {
      VERDICT_EQUAL   = 2'd0,
      VERDICT_LESS    = 2'd1,
      VERDICT_GREATER = 2'd2
   } rpkc_verdict_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } rpkc_req_type;

   typedef struct packed {
      logic                  key_valid;
      logic [KEY_BITS_W-1:0] key_bit_length;
   } rpkc_rsp_type;

   // Work handed from the byte parser to the modulus store and compare stage.
   typedef struct packed {
      logic                  write;
      logic                  compare;
      logic                  last;
      logic                  ok;
      logic [BYTE_W-1:0]     data;
      logic [KEY_BITS_W-1:0] bit_len;
   } rpkc_stage_ctl_type;

   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic                  key_valid;
      logic [KEY_BITS_W-1:0] bit_len;
   } rpkc_stage_res_type;

   function automatic logic [TOP_BITS_W-1:0] bit_length8(input logic [BYTE_W-1:0] b);
      logic [TOP_BITS_W-1:0] n;
      n = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         if (b[k]) begin
            n = TOP_BITS_W'(k + 1);
         end
      end
      return n;
   endfunction

endpackage

@@ sv/rpkc_modulus_cmp.sv @@
module rpkc_modulus_cmp
   import rpkc_pkg::*;
#(
   parameter int MAX_MODULUS_BYTES = MAX_MODULUS_BYTES_DEF,
   parameter int AW = (MAX_MODULUS_BYTES > 1) ? $clog2(MAX_MODULUS_BYTES) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               stage_valid,
   input  rpkc_stage_ctl_type stage_ctl,
   input  logic [AW-1:0]      stage_addr,
   input  logic               advance,
   output rpkc_stage_res_type stage_res
);

   logic [BYTE_W-1:0] modulus_mem [MAX_MODULUS_BYTES];
   logic [BYTE_W-1:0] rd_q_ff;

   logic               s2_valid_ff;
   rpkc_stage_ctl_type s2_ctl_ff;
   rpkc_verdict_type   verdict_ff;
   rpkc_verdict_type   verdict_in;
   rpkc_verdict_type   verdict_nx;

   // A modulus byte is always written in an earlier transfer than the exponent
   // byte that reads the same entry, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (stage_valid && stage_ctl.write) begin
         modulus_mem[stage_addr] <= stage_ctl.data;
      end
      if (stage_valid && stage_ctl.compare) begin
         rd_q_ff <= modulus_mem[stage_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         verdict_ff  <= VERDICT_EQUAL;
      end else begin
         if (advance) begin
            s2_valid_ff <= stage_valid;
         end
         verdict_ff <= verdict_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ctl_ff <= stage_ctl;
      end
   end

   always_comb begin
      verdict_nx = verdict_ff;
      if (s2_valid_ff && s2_ctl_ff.compare && verdict_ff == VERDICT_EQUAL
          && s2_ctl_ff.data != rd_q_ff) begin
         verdict_nx = (s2_ctl_ff.data < rd_q_ff) ? VERDICT_LESS : VERDICT_GREATER;
      end
      verdict_in = verdict_ff;
      if (s2_valid_ff && advance) begin
         verdict_in = s2_ctl_ff.last ? VERDICT_EQUAL : verdict_nx;
      end
   end

   always_comb begin
      stage_res.valid     = s2_valid_ff;
      stage_res.last      = s2_ctl_ff.last;
      stage_res.key_valid = s2_ctl_ff.ok && (verdict_nx == VERDICT_LESS);
      stage_res.bit_len   = stage_res.key_valid ? s2_ctl_ff.bit_len : '0;
   end

endmodule

@@ sv/rsa_public_key_encoding_check_core.sv @@
// The last byte is registered into the compare stage, then its verdict into the
// output register. Throughput: one byte per cycle unless rsp backs up; each byte
// does at most one write or one read of the single-port modulus memory, and the
// exponent compare runs one stage behind.
// Reset is synchronous and active high; it clears control state and restores
// the register defaults. The modulus memory is not cleared and needs no sweep.
`include "rsa_public_key_encoding_check_core_macros.svh"

module rsa_public_key_encoding_check_core
   import rpkc_pkg::*;
#(
   parameter int MAX_MODULUS_BYTES = MAX_MODULUS_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rpkc_req_type           req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rpkc_rsp_type           rsp_item,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [KEY_BITS_W-1:0]  csr_wdata
);

   localparam int AW = (MAX_MODULUS_BYTES > 1) ? $clog2(MAX_MODULUS_BYTES) : 1;

   logic [KEY_BITS_W-1:0]  min_key_bits_ff;
   logic [KEY_BITS_W-1:0]  max_key_bits_ff;
   logic [ENC_BYTES_W-1:0] max_enc_bytes_ff;

   logic [ENC_BYTES_W-1:0] byte_pos_ff,      byte_pos_in;
   logic [DECL_W-1:0]      declared_bits_ff, declared_bits_in;
   logic                   upper_nz_ff,      upper_nz_in;
   logic                   flags_ok_ff,      flags_ok_in;
   logic [TOP_BITS_W-1:0]  top_bits_ff,      top_bits_in;
   logic [BYTE_W-1:0]      last_exp_ff,      last_exp_in;

   logic                   rsp_valid_ff;
   rpkc_rsp_type           rsp_item_ff;

   logic                   req_accept;
   logic                   s2_last;
   logic                   s2_stall;
   logic                   rsp_bad_len;
   rpkc_stage_ctl_type     stage_ctl;
   rpkc_stage_res_type     stage_res;
   logic [AW-1:0]          stage_addr;

   logic                   in_range;
   logic [WIDTH_W+2:0]     width_sum;
   logic [WIDTH_W-1:0]     width;
   logic                   width_ok;
   logic [ENC_BYTES_W:0]   pos_ext;
   logic [ENC_BYTES_W:0]   mod_end;
   logic [ENC_BYTES_W+1:0] exp_end;
   logic [ENC_BYTES_W:0]   exp_diff;
   logic [ENC_BYTES_W-1:0] mod_idx;
   logic                   is_header, is_mod, is_exp;
   logic                   mod_first, mod_last, exp_upper;

   logic [ENC_BYTES_W-1:0] pos_nx;
   logic [DECL_W-1:0]      declared_nx;
   logic                   upper_nz_nx, flags_ok_nx;
   logic [TOP_BITS_W-1:0]  top_bits_nx;
   logic [BYTE_W-1:0]      last_exp_nx;
   logic [WIDTH_W-1:0]     width_m1;
   logic [WIDTH_W+2:0]     bit_len_sum;
   logic                   frame_ok;

   assign req_accept = req_valid && req_ready;
   assign s2_last    = stage_res.valid && stage_res.last;
   assign s2_stall   = s2_last && rsp_valid_ff && !rsp_ready;
   assign req_ready  = !s2_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_key_bits_ff  <= MIN_KEY_BITS_RST;
         max_key_bits_ff  <= MAX_KEY_BITS_RST;
         max_enc_bytes_ff <= MAX_ENC_BYTES_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_KEY_BITS:  min_key_bits_ff  <= csr_wdata;
            CSR_MAX_KEY_BITS:  max_key_bits_ff  <= csr_wdata;
            CSR_MAX_ENC_BYTES: max_enc_bytes_ff <= csr_wdata[ENC_BYTES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Usable modulus width in bytes, taken from the header once it is complete.
   always_comb begin
      in_range  = (declared_bits_ff >= DECL_W'(min_key_bits_ff))
                  && (declared_bits_ff <= DECL_W'(max_key_bits_ff));
      width_sum = {1'b0, declared_bits_ff[KEY_BITS_W-1:0]} + (WIDTH_W+3)'(7);
      width     = width_sum[WIDTH_W+2:3];
      width_ok  = in_range && (width != '0)
                  && ({1'b0, width} <= (WIDTH_W+1)'(MAX_MODULUS_BYTES));

      pos_ext   = {1'b0, byte_pos_ff};
      mod_end   = (ENC_BYTES_W+1)'(HEADER_BYTES) + {1'b0, width};
      exp_end   = (ENC_BYTES_W+2)'(HEADER_BYTES) + {1'b0, width, 1'b0};
      exp_diff  = pos_ext - mod_end;
      mod_idx   = byte_pos_ff - ENC_BYTES_W'(HEADER_BYTES);

      is_header = byte_pos_ff < ENC_BYTES_W'(HEADER_BYTES);
      is_mod    = !is_header && width_ok && (pos_ext < mod_end);
      is_exp    = !is_header && width_ok && !is_mod && ({1'b0, pos_ext} < exp_end);
      mod_first = is_mod && (mod_idx == '0);
      mod_last  = is_mod && (mod_idx == width - WIDTH_W'(1));
      exp_upper = is_exp && (({1'b0, pos_ext} + (ENC_BYTES_W+2)'(1)) < exp_end);

      stage_addr = is_mod ? mod_idx[AW-1:0] : exp_diff[AW-1:0];
   end

   always_comb begin
      declared_nx = declared_bits_ff;
      upper_nz_nx = upper_nz_ff;
      flags_ok_nx = flags_ok_ff;
      top_bits_nx = top_bits_ff;
      last_exp_nx = last_exp_ff;
      pos_nx      = (byte_pos_ff == POSITION_MAX) ? byte_pos_ff
                                                   : byte_pos_ff + ENC_BYTES_W'(1);
      if (is_header) begin
         declared_nx = {declared_bits_ff[DECL_W-BYTE_W-1:0], req_item.data_byte};
      end
      if (mod_first) begin
         top_bits_nx = bit_length8(req_item.data_byte);
         if (req_item.data_byte == '0) begin
            flags_ok_nx = 1'b0;
         end
      end
      if (mod_last && !req_item.data_byte[0]) begin
         flags_ok_nx = 1'b0;
      end
      if (is_exp) begin
         last_exp_nx = req_item.data_byte;
         if (exp_upper && req_item.data_byte != '0) begin
            upper_nz_nx = 1'b1;
         end
      end

      // Everything but the exponent-below-modulus test is settled here; the
      // compare stage adds that one.
      frame_ok = (pos_nx >= ENC_BYTES_W'(HEADER_BYTES)) && width_ok
                 && ({2'b00, pos_nx} == exp_end)
                 && (pos_nx <= max_enc_bytes_ff)
                 && flags_ok_nx && last_exp_nx[0]
                 && (upper_nz_nx || last_exp_nx > BYTE_W'(1));
      width_m1    = width - WIDTH_W'(1);
      bit_len_sum = {width_m1, 3'b000} + (WIDTH_W+3)'(top_bits_nx);

      stage_ctl.write   = is_mod;
      stage_ctl.compare = is_exp;
      stage_ctl.last    = req_item.last_byte;
      stage_ctl.ok      = frame_ok;
      stage_ctl.data    = req_item.data_byte;
      stage_ctl.bit_len = bit_len_sum[KEY_BITS_W-1:0];

      byte_pos_in      = byte_pos_ff;
      declared_bits_in = declared_bits_ff;
      upper_nz_in      = upper_nz_ff;
      flags_ok_in      = flags_ok_ff;
      top_bits_in      = top_bits_ff;
      last_exp_in      = last_exp_ff;
      if (req_accept) begin
         if (req_item.last_byte) begin
            byte_pos_in      = '0;
            declared_bits_in = '0;
            upper_nz_in      = 1'b0;
            flags_ok_in      = 1'b1;
            top_bits_in      = '0;
            last_exp_in      = '0;
         end else begin
            byte_pos_in      = pos_nx;
            declared_bits_in = declared_nx;
            upper_nz_in      = upper_nz_nx;
            flags_ok_in      = flags_ok_nx;
            top_bits_in      = top_bits_nx;
            last_exp_in      = last_exp_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff      <= '0;
         declared_bits_ff <= '0;
         upper_nz_ff      <= 1'b0;
         flags_ok_ff      <= 1'b1;
         top_bits_ff      <= '0;
         last_exp_ff      <= '0;
      end else begin
         byte_pos_ff      <= byte_pos_in;
         declared_bits_ff <= declared_bits_in;
         upper_nz_ff      <= upper_nz_in;
         flags_ok_ff      <= flags_ok_in;
         top_bits_ff      <= top_bits_in;
         last_exp_ff      <= last_exp_in;
      end
   end

   rpkc_modulus_cmp #(
      .MAX_MODULUS_BYTES (MAX_MODULUS_BYTES),
      .AW                (AW)
   ) u_modulus_cmp (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (req_accept),
      .stage_ctl   (stage_ctl),
      .stage_addr  (stage_addr),
      .advance     (!s2_stall),
      .stage_res   (stage_res)
   );

   // Output register: a finished verdict waits here while new bytes flow in.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_res.valid && stage_res.last && !s2_stall) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_res.valid && stage_res.last && !s2_stall) begin
         rsp_item_ff.key_valid      <= stage_res.key_valid;
         rsp_item_ff.key_bit_length <= stage_res.bit_len;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign rsp_bad_len = rsp_valid_ff && !rsp_item_ff.key_valid
                        && (rsp_item_ff.key_bit_length != '0);

   `RPKC_NEVER(a_write_and_compare, clock, reset, stage_ctl.write && stage_ctl.compare)
   `RPKC_ASSERT(a_result_from_last, clock, reset, $rose(rsp_valid_ff) |-> $past(s2_last))
   `RPKC_NEVER(a_invalid_zero_len, clock, reset, rsp_bad_len)
   `RPKC_ASSERT(a_pos_advances, clock, reset, req_accept && !req_item.last_byte |=> byte_pos_ff != '0)

endmodule

@@ sim/rsa_public_key_encoding_check_core_tb.sv @@
`timescale 1ns / 1ps

module rsa_public_key_encoding_check_core_tb;
   import rpkc_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_TARGET = 1450;
   localparam int CALM_FROM   = 1250;

   typedef enum int {
      FLAW_NONE,
      FLAW_MOD_EVEN,
      FLAW_MOD_TOP_ZERO,
      FLAW_EXP_EVEN,
      FLAW_EXP_EQUAL,
      FLAW_EXP_GREATER,
      FLAW_EXP_ONE,
      FLAW_SHORT,
      FLAW_SURPLUS,
      FLAW_RANGE
   } encoding_flaw_type;

   // Mirrors the key checker: tracks one encoding at a time and queues the
   // verdict that each final byte should produce.
   class key_verdict_board;
      logic [KEY_BITS_W-1:0]  min_bits;
      logic [KEY_BITS_W-1:0]  max_bits;
      logic [ENC_BYTES_W-1:0] max_bytes;
      int unsigned            position;
      logic [DECL_W-1:0]      declared;
      logic [BYTE_W-1:0]      modulus_copy [MAX_MODULUS_BYTES_DEF];
      rpkc_verdict_type       order;
      logic                   exp_upper_nz;
      logic                   modulus_ok;
      int unsigned            top_bits;
      logic [BYTE_W-1:0]      exp_tail;
      rpkc_rsp_type           pending_verdicts [$];
      int                     failures;

      function new();
         min_bits = MIN_KEY_BITS_RST;
         max_bits = MAX_KEY_BITS_RST;
         max_bytes = MAX_ENC_BYTES_RST;
         failures = 0;
         clear_encoding();
      endfunction

      function void clear_encoding();
         position = 0;
         declared = '0;
         order = VERDICT_EQUAL;
         exp_upper_nz = 1'b0;
         modulus_ok = 1'b1;
         top_bits = 0;
         exp_tail = '0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [KEY_BITS_W-1:0] value);
         case (index)
            CSR_MIN_KEY_BITS: min_bits = value;
            CSR_MAX_KEY_BITS: max_bits = value;
            CSR_MAX_ENC_BYTES: max_bytes = value[ENC_BYTES_W-1:0];
            default: ;
         endcase
      endfunction

      // Bytes per number, or zero when the declared count cannot be used.
      function int unsigned modulus_width();
         logic [63:0] w;
         if (declared < min_bits || declared > max_bits) return 0;
         w = ({32'd0, declared} + 64'd7) / 64'd8;
         if (w > MAX_MODULUS_BYTES_DEF) return 0;
         return w[31:0];
      endfunction

      function void absorb_byte(rpkc_req_type item);
         int unsigned  w;
         int unsigned  slot;
         logic [7:0]   t;
         logic         key_ok;
         rpkc_rsp_type verdict;
         if (position < HEADER_BYTES) begin
            declared = {declared[23:0], item.data_byte};
         end else begin
            w = modulus_width();
            if (w != 0 && position < HEADER_BYTES + w) begin
               slot = position - HEADER_BYTES;
               modulus_copy[slot] = item.data_byte;
               if (slot == 0) begin
                  if (item.data_byte == 0) modulus_ok = 1'b0;
                  top_bits = 0;
                  for (t = item.data_byte; t != 0; t = t >> 1) top_bits++;
               end
               if (slot == w - 1 && !item.data_byte[0]) modulus_ok = 1'b0;
            end else if (w != 0 && position < HEADER_BYTES + 2 * w) begin
               slot = position - HEADER_BYTES - w;
               if (order == VERDICT_EQUAL && item.data_byte != modulus_copy[slot]) begin
                  order = (item.data_byte < modulus_copy[slot]) ? VERDICT_LESS
                                                                : VERDICT_GREATER;
               end
               if (slot + 1 < w && item.data_byte != 0) exp_upper_nz = 1'b1;
               exp_tail = item.data_byte;
            end
         end
         if (position < POSITION_MAX) position++;
         if (!item.last_byte) return;

         w = (position >= HEADER_BYTES) ? modulus_width() : 0;
         key_ok = w != 0 && position == HEADER_BYTES + 2 * w && position <= max_bytes
                  && modulus_ok && exp_tail[0] && order == VERDICT_LESS
                  && (exp_upper_nz || exp_tail > 1);
         verdict.key_valid = key_ok;
         verdict.key_bit_length = key_ok ? KEY_BITS_W'((w - 1) * 8 + top_bits) : '0;
         pending_verdicts.push_back(verdict);
         clear_encoding();
      endfunction

      function void match_verdict(rpkc_rsp_type seen);
         rpkc_rsp_type want;
         if (pending_verdicts.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("Verdict with none expected: valid=%0d bits=%0d",
                        seen.key_valid, seen.key_bit_length);
            return;
         end
         want = pending_verdicts.pop_front();
         if (seen.key_valid !== want.key_valid
             || seen.key_bit_length !== want.key_bit_length) begin
            failures++;
            if (failures <= 10)
               $display("Verdict mismatch: expected valid=%0d bits=%0d, got valid=%0d bits=%0d",
                        want.key_valid, want.key_bit_length,
                        seen.key_valid, seen.key_bit_length);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   rpkc_req_type           req_item = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rpkc_rsp_type           rsp_item;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MIN_KEY_BITS;
   logic [KEY_BITS_W-1:0]  csr_wdata = '0;

   logic            bursts_on = 1'b1;
   logic            hold_outputs = 1'b0;
   int              quiet_cycles = 0;
   rpkc_req_type    encoding_q [$];
   key_verdict_board verdicts = new();

   rsa_public_key_encoding_check_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) verdicts.absorb_byte(req_item);
         if (rsp_valid && rsp_ready) verdicts.match_verdict(rsp_item);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result side: mostly ready, with stall bursts, calm stretches and one long hold.
   initial begin
      int unsigned mode;
      forever begin
         mode = $urandom_range(0, 9);
         if (hold_outputs) begin
            hold_outputs = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (bursts_on && mode == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else if (mode == 1) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      rpkc_req_type item;
      item.data_byte = b;
      item.last_byte = 1'b0;
      encoding_q.push_back(item);
   endtask

   task automatic push_word(input logic [31:0] v);
      for (int i = 3; i >= 0; i--) push_byte(v[8*i +: 8]);
   endtask

   // Sends the queued encoding with the flag on its final byte.
   task automatic send_encoding();
      rpkc_req_type tail;
      logic         gappy;
      tail = encoding_q.pop_back();
      tail.last_byte = 1'b1;
      encoding_q.push_back(tail);
      gappy = $urandom_range(0, 2) != 0;
      foreach (encoding_q[i]) begin
         if (bursts_on && gappy && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_item <= encoding_q[i];
         do @(posedge clock); while (!req_ready);
      end
      encoding_q.delete();
   endtask

   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts.pending_verdicts.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic program_limits(input logic [13:0] lo, input logic [13:0] hi,
                                 input logic [13:0] enc);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MIN_KEY_BITS;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_KEY_BITS;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_MAX_ENC_BYTES;
      csr_wdata <= enc;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      verdicts.write_register(CSR_MIN_KEY_BITS, lo);
      verdicts.write_register(CSR_MAX_KEY_BITS, hi);
      verdicts.write_register(CSR_MAX_ENC_BYTES, enc);
   endtask

   // Builds a key encoding that fits the current limits, then spoils it
   // in the way the flaw asks for.
   task automatic build_key(input encoding_flaw_type flaw);
      int unsigned lo;
      int unsigned hi;
      int unsigned bits;
      int unsigned w;
      int unsigned k;
      logic [7:0]  modv [$];
      logic [7:0]  expv [$];
      lo = verdicts.min_bits;
      hi = verdicts.max_bits;
      if (flaw == FLAW_RANGE)
         bits = (lo > 0 && $urandom_range(0, 1)) ? lo - 1 : hi + 1 + $urandom_range(0, 40);
      else if (lo > hi)
         bits = lo;
      else
         bits = $urandom_range(lo, (hi - lo > 63) ? lo + 63 : hi);
      w = (bits + 7) / 8;
      // Unusable counts have their number bytes ignored, so keep those short.
      if (w == 0 || w > MAX_MODULUS_BYTES_DEF || flaw == FLAW_RANGE || lo > hi)
         w = $urandom_range(1, 4);

      for (int i = 0; i < w; i++) modv.push_back(8'($urandom_range(0, 255)));
      modv[0] = 8'($urandom_range(1, 255) >> $urandom_range(0, 7));
      if (modv[0] == 0) modv[0] = 8'h01;
      modv[w-1] = modv[w-1] | 8'h01;

      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i + 1 < w; i++) expv.push_back(8'h00);
         expv.push_back(8'($urandom_range(1, 127) * 2 + 1));
      end else begin
         k = $urandom_range(0, w - 1);
         for (int i = 0; i < w; i++) begin
            if (i < k) expv.push_back(modv[i]);
            else if (i == k) expv.push_back(modv[i] == 0 ? 8'h00
                                            : 8'($urandom_range(0, modv[i] - 1)));
            else expv.push_back(8'($urandom_range(0, 255)));
         end
         expv[w-1] = expv[w-1] | 8'h01;
      end

      case (flaw)
         FLAW_MOD_EVEN: modv[w-1] = modv[w-1] & 8'hFE;
         FLAW_MOD_TOP_ZERO: modv[0] = 8'h00;
         FLAW_EXP_EVEN: expv[w-1] = expv[w-1] & 8'hFE;
         FLAW_EXP_EQUAL: expv = modv;
         FLAW_EXP_GREATER: begin
            expv = modv;
            for (int i = 0; i < w; i++) begin
               if (modv[i] != 8'hFF) begin
                  expv[i] = modv[i] + 8'd1;
                  break;
               end
            end
         end
         FLAW_EXP_ONE: begin
            foreach (expv[i]) expv[i] = 8'h00;
            expv[w-1] = 8'h01;
         end
         default: ;
      endcase

      push_word(bits);
      foreach (modv[i]) push_byte(modv[i]);
      foreach (expv[i]) push_byte(expv[i]);
      if (flaw == FLAW_SHORT) void'(encoding_q.pop_back());
      if (flaw == FLAW_SURPLUS)
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int          phase;
      int unsigned sent;
      int unsigned budget;
      int unsigned random_bytes;
      int unsigned pick;
      logic [13:0] lo;
      logic [13:0] hi;
      logic [13:0] enc;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Too short to hold even the header.
      push_byte(8'h00);
      push_byte(8'hFF);
      send_encoding();
      // Count below the reset minimum, with trailing bytes that are ignored.
      push_word(32'd16);
      push_byte(8'h81);
      push_byte(8'h7E);
      push_byte(8'h01);
      send_encoding();

      drain_results(5);
      program_limits(14'd0, 14'h3FFF, 14'd2052);
      // A declared count of zero gives no width at all.
      push_word(32'd0);
      push_byte(8'hAA);
      push_byte(8'h55);
      send_encoding();
      // One byte beyond the modulus store.
      push_word(32'd8200);
      repeat (4) push_byte(8'($urandom_range(0, 255)));
      send_encoding();
      // Smallest good key.
      push_word(32'd8);
      push_byte(8'hFF);
      push_byte(8'hFD);
      send_encoding();
      // Exponent of one.
      push_word(32'd3);
      push_byte(8'h07);
      push_byte(8'h01);
      send_encoding();

      random_bytes = 0;
      for (phase = 0; random_bytes < ITEM_TARGET; phase++) begin
         drain_results(5);
         budget = 150;
         case (phase)
            0: begin lo = 14'd1; hi = 14'd64; enc = 14'd2052; end
            1: begin lo = 14'd1024; hi = 14'd1024; enc = 14'd2052; budget = 1; end
            2: begin lo = 14'd1; hi = 14'd8192; enc = 14'd4; budget = 60; end
            3: begin
               lo = 14'($urandom_range(1, 32));
               hi = lo + 14'($urandom_range(0, 64));
               enc = 14'($urandom_range(8, 40));
            end
            4: begin lo = 14'd40; hi = 14'd20; enc = 14'd2052; budget = 60; end
            5: begin lo = 14'd1; hi = 14'd100; enc = 14'h3FFF; end
            default: begin
               lo = 14'($urandom_range(1, 48));
               hi = lo + 14'($urandom_range(0, 80));
               enc = $urandom_range(0, 1) ? 14'd2052 : 14'($urandom_range(4, 48));
            end
         endcase
         program_limits(lo, hi, enc);
         // Results back up behind a long hold until the input stalls.
         if (phase == 3) hold_outputs = 1'b1;
         sent = 0;
         while (sent < budget) begin
            bursts_on = random_bytes < CALM_FROM;
            pick = $urandom_range(0, 99);
            if (phase == 1) begin
               build_key(FLAW_NONE);
            end else if (pick < 78) begin
               pick = $urandom_range(0, 16);
               build_key(pick < 8 ? FLAW_NONE : encoding_flaw_type'(pick - 7));
            end else begin
               repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
            end
            sent += encoding_q.size();
            random_bytes += encoding_q.size();
            send_encoding();
         end
      end

      drain_results(10);
      if (verdicts.failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/rpkc_pkg.sv
sv/rpkc_modulus_cmp.sv
sv/rsa_public_key_encoding_check_core.sv
sim/rsa_public_key_encoding_check_core_tb.sv
